// ===== rtl/rgb_pixel_point_effects_defines.svh =====
// Assertion macros for the pixel point effects block
`ifndef RGB_PIXEL_POINT_EFFECTS_DEFINES_SVH
`define RGB_PIXEL_POINT_EFFECTS_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed: lbl");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("assertion failed: lbl");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/rppe_pkg.sv =====
// Types, constants and arithmetic helpers for the pixel point effects block
`timescale 1ns / 1ps
`default_nettype none

package rppe_pkg;

	localparam logic [2:0] MODE_BRIGHTEN = 3'd0;
	localparam logic [2:0] MODE_DARKEN   = 3'd1;
	localparam logic [2:0] MODE_HOT      = 3'd2;
	localparam logic [2:0] MODE_COOL     = 3'd3;
	localparam logic [2:0] MODE_GRAY     = 3'd4;
	localparam logic [2:0] MODE_CONTRAST = 3'd5;

	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_BRIGHTEN = 3'd1;
	localparam logic [2:0] REG_DARKEN   = 3'd2;
	localparam logic [2:0] REG_TINT     = 3'd3;
	localparam logic [2:0] REG_GAIN     = 3'd4;

	localparam logic [2:0]  RST_MODE     = MODE_BRIGHTEN;
	localparam logic [7:0]  RST_BRIGHTEN = 8'd30;
	localparam logic [7:0]  RST_DARKEN   = 8'd50;
	localparam logic [7:0]  RST_TINT     = 8'd30;
	localparam logic [11:0] RST_GAIN     = 12'd581;

	localparam logic [9:0] RECIP3 = 10'd683;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  brighten_step;
		logic [7:0]  darken_step;
		logic [7:0]  tint_step;
		logic [11:0] contrast_gain;
	} cfg_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	function automatic logic [7:0] sat8(input logic signed [13:0] v);
		logic [7:0] r;
		if (v < 14'sd0) begin
			r = 8'd0;
		end else if (v > 14'sd255) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] add_sat(input logic [7:0] c, input logic [7:0] step);
		logic signed [13:0] s;
		s = $signed({6'd0, c}) + $signed({6'd0, step});
		return sat8(s);
	endfunction

	function automatic logic [7:0] sub_sat(input logic [7:0] c, input logic [7:0] step);
		logic signed [13:0] s;
		s = $signed({6'd0, c}) - $signed({6'd0, step});
		return sat8(s);
	endfunction

	function automatic logic [7:0] contrast8(input logic [7:0] c, input logic [11:0] gain);
		logic signed [7:0]  d;
		logic signed [12:0] g;
		logic signed [20:0] p;
		logic signed [13:0] s;
		d = $signed({~c[7], c[6:0]});
		g = $signed({1'b0, gain});
		p = g * d;
		s = $signed({p[20], p[20:8]}) + 14'sd128;
		return sat8(s);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rppe_cfg_regs.sv =====
// Configuration register file for the pixel point effects block
`timescale 1ns / 1ps
`default_nettype none

module rppe_cfg_regs (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [11:0]      cfg_data,
	output rppe_pkg::cfg_t        cfg
);

	rppe_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= rppe_pkg::RST_MODE;
			cfg_q.brighten_step <= rppe_pkg::RST_BRIGHTEN;
			cfg_q.darken_step   <= rppe_pkg::RST_DARKEN;
			cfg_q.tint_step     <= rppe_pkg::RST_TINT;
			cfg_q.contrast_gain <= rppe_pkg::RST_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rppe_pkg::REG_MODE:     cfg_q.mode          <= cfg_data[2:0];
				rppe_pkg::REG_BRIGHTEN: cfg_q.brighten_step <= cfg_data[7:0];
				rppe_pkg::REG_DARKEN:   cfg_q.darken_step   <= cfg_data[7:0];
				rppe_pkg::REG_TINT:     cfg_q.tint_step     <= cfg_data[7:0];
				rppe_pkg::REG_GAIN:     cfg_q.contrast_gain <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rppe_core.sv =====
// Per-pixel effect datapath and result register
`timescale 1ns / 1ps
`default_nettype none

module rppe_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_s1,
	input  wire rppe_pkg::pixel_t pix_s1,
	input  wire rppe_pkg::cfg_t  cfg,
	output logic                 valid_s2,
	output rppe_pkg::pixel_t     pix_s2
);

	rppe_pkg::pixel_t res;
	logic [9:0]       sum;
	logic [19:0]      prod;
	logic [7:0]       avg;

	assign sum  = {2'd0, pix_s1.blue} + {2'd0, pix_s1.green} + {2'd0, pix_s1.red};
	assign prod = sum * rppe_pkg::RECIP3;
	assign avg  = prod[18:11];

	always_comb begin
		res = pix_s1;
		case (cfg.mode)
			rppe_pkg::MODE_BRIGHTEN: begin
				res.blue  = rppe_pkg::add_sat(pix_s1.blue,  cfg.brighten_step);
				res.green = rppe_pkg::add_sat(pix_s1.green, cfg.brighten_step);
				res.red   = rppe_pkg::add_sat(pix_s1.red,   cfg.brighten_step);
			end
			rppe_pkg::MODE_DARKEN: begin
				res.blue  = rppe_pkg::sub_sat(pix_s1.blue,  cfg.darken_step);
				res.green = rppe_pkg::sub_sat(pix_s1.green, cfg.darken_step);
				res.red   = rppe_pkg::sub_sat(pix_s1.red,   cfg.darken_step);
			end
			rppe_pkg::MODE_HOT: begin
				res.red = rppe_pkg::add_sat(pix_s1.red, cfg.tint_step);
			end
			rppe_pkg::MODE_COOL: begin
				res.blue = rppe_pkg::add_sat(pix_s1.blue, cfg.tint_step);
			end
			rppe_pkg::MODE_GRAY: begin
				res.blue  = avg;
				res.green = avg;
				res.red   = avg;
			end
			rppe_pkg::MODE_CONTRAST: begin
				res.blue  = rppe_pkg::contrast8(pix_s1.blue,  cfg.contrast_gain);
				res.green = rppe_pkg::contrast8(pix_s1.green, cfg.contrast_gain);
				res.red   = rppe_pkg::contrast8(pix_s1.red,   cfg.contrast_gain);
			end
			default: res = pix_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s2 <= res;
	end

endmodule

`default_nettype wire

// ===== rtl/rgb_pixel_point_effects.sv =====
// Pixel point effects: one BGR pixel per clock through a two-register datapath.
// A pixel is taken on every clock with start high (busy stays low), and its
// result appears on blue_out/green_out/red_out with done high for exactly one
// cycle, after one input register, the effect logic and one result register,
// in that order. Throughput is one pixel per clock; the receiver
// cannot stall the block, so done must be sampled when it is high. Write the
// configuration registers only while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_pixel_point_effects_defines.svh"

module rgb_pixel_point_effects (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  blue_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  red_in,
	output logic             done,
	output logic [7:0]       blue_out,
	output logic [7:0]       green_out,
	output logic [7:0]       red_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	rppe_pkg::cfg_t   cfg;
	rppe_pkg::pixel_t pix_s1;
	rppe_pkg::pixel_t pix_s2;
	logic             valid_s1;
	logic             valid_s2;

	assign busy = 1'b0;

	rppe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1.blue  <= blue_in;
		pix_s1.green <= green_in;
		pix_s1.red   <= red_in;
	end

	rppe_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.pix_s1   (pix_s1),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.pix_s2   (pix_s2)
	);

	assign done      = valid_s2;
	assign blue_out  = pix_s2.blue;
	assign green_out = pix_s2.green;
	assign red_out   = pix_s2.red;

	`ASSERT_PROP(a_req_done, clk, arst_n, (start && !busy) |=> ##1 done)
	`ASSERT_PROP(a_no_spurious_done, clk, arst_n, !(start && !busy) |=> ##1 !done)
	`ASSERT_NEVER(a_never_busy, clk, arst_n, busy)
	`ASSERT_PROP(a_gray_equal, clk, arst_n, (done && $past(cfg.mode) == rppe_pkg::MODE_GRAY) |-> (blue_out == green_out && green_out == red_out))

endmodule

`default_nettype wire
